/* rtl/hack_cpu_instruction_step_assert.svh */
// assertion macros for the hack cpu instruction step block
`ifndef HACK_CPU_INSTRUCTION_STEP_ASSERT_SVH
`define HACK_CPU_INSTRUCTION_STEP_ASSERT_SVH

`ifndef SYNTH
`define HCIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcis assertion failed: same-cycle implication");
`define HCIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcis assertion failed: next-cycle implication");
`else
`define HCIS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HCIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/hcis_pkg.sv */
// shared types and constants for the hack cpu instruction step block
`timescale 1ns / 1ps
`default_nettype none

package hcis_pkg;

    typedef logic [15:0] word_t;
    typedef logic [1:0]  status_t;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_BAD    = 2'd1;
    localparam status_t ST_RANGE  = 2'd2;
    localparam status_t ST_HALTED = 2'd3;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        CFG_PROGRAM_LENGTH = 1'b0;
    localparam word_t       PROGRAM_LENGTH_RST = 16'h8000;
    localparam word_t       A_LOAD_MASK = 16'h7FFF;

    // comp field codes (c1..c6)
    localparam logic [5:0] COMP_ZERO    = 6'h2A;
    localparam logic [5:0] COMP_ONE     = 6'h3F;
    localparam logic [5:0] COMP_NEG_ONE = 6'h3A;
    localparam logic [5:0] COMP_D       = 6'h0C;
    localparam logic [5:0] COMP_NOT_D   = 6'h0D;
    localparam logic [5:0] COMP_NEG_D   = 6'h0F;
    localparam logic [5:0] COMP_D_INC   = 6'h1F;
    localparam logic [5:0] COMP_D_DEC   = 6'h0E;
    localparam logic [5:0] COMP_Y       = 6'h30;
    localparam logic [5:0] COMP_NOT_Y   = 6'h31;
    localparam logic [5:0] COMP_NEG_Y   = 6'h33;
    localparam logic [5:0] COMP_Y_INC   = 6'h37;
    localparam logic [5:0] COMP_Y_DEC   = 6'h32;
    localparam logic [5:0] COMP_D_ADD_Y = 6'h02;
    localparam logic [5:0] COMP_D_SUB_Y = 6'h13;
    localparam logic [5:0] COMP_Y_SUB_D = 6'h07;
    localparam logic [5:0] COMP_D_AND_Y = 6'h00;
    localparam logic [5:0] COMP_D_OR_Y  = 6'h15;

    typedef struct packed {
        logic  ok;
        word_t res;
        logic  take;
    } alu_out_t;

    typedef struct packed {
        logic  re;
        word_t raddr;
        logic  we;
        word_t waddr;
        word_t wdata;
    } mem_req_t;

endpackage

`default_nettype wire

/* rtl/hcis_if.sv */
// handshake channels for instruction items and result items
`timescale 1ns / 1ps
`default_nettype none

interface hcis_instr_if import hcis_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t instruction;

    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

interface hcis_result_if import hcis_pkg::*; ();
    logic               valid;
    logic               ready;
    word_t              next_pc;
    logic signed [15:0] a_value;
    logic signed [15:0] d_value;
    logic               jumped;
    status_t            status;

    modport source (output valid, output next_pc, output a_value, output d_value,
                    output jumped, output status, input ready);
    modport sink (input valid, input next_pc, input a_value, input d_value,
                  input jumped, input status, output ready);
endinterface

`default_nettype wire

/* rtl/hcis_cfg.sv */
// apb configuration register file
`timescale 1ns / 1ps
`default_nettype none

module hcis_cfg import hcis_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output word_t                      program_length
);

    word_t prog_len_reg;
    word_t prog_len_next;
    logic  reg_sel;
    logic  wr_en;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == CFG_PROGRAM_LENGTH);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        prog_len_next = prog_len_reg;
        if (wr_en && reg_sel)
        begin
            prog_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= PROGRAM_LENGTH_RST;
        end
        else
        begin
            prog_len_reg <= prog_len_next;
        end
    end

    assign prdata         = reg_sel ? {16'h0000, prog_len_reg} : 32'h0000_0000;
    assign program_length = prog_len_reg;

endmodule

`default_nettype wire

/* rtl/hcis_alu.sv */
// hack alu with comp decode and jump condition
`timescale 1ns / 1ps
`default_nettype none

module hcis_alu import hcis_pkg::*;
(
    input  wire logic [5:0] comp,
    input  wire logic       use_m,
    input  wire logic [2:0] jbits,
    input  wire word_t      d,
    input  wire word_t      y,
    output alu_out_t        out
);

    word_t res;
    logic  known;
    logic  d_only;
    logic  neg;
    logic  zero;

    always_comb
    begin
        res    = '0;
        known  = 1'b1;
        d_only = 1'b0;
        unique case (comp)
            COMP_ZERO:    begin res = 16'h0000;        d_only = 1'b1; end
            COMP_ONE:     begin res = 16'h0001;        d_only = 1'b1; end
            COMP_NEG_ONE: begin res = 16'hFFFF;        d_only = 1'b1; end
            COMP_D:       begin res = d;               d_only = 1'b1; end
            COMP_NOT_D:   begin res = ~d;              d_only = 1'b1; end
            COMP_NEG_D:   begin res = 16'h0000 - d;    d_only = 1'b1; end
            COMP_D_INC:   begin res = d + 16'h0001;    d_only = 1'b1; end
            COMP_D_DEC:   begin res = d - 16'h0001;    d_only = 1'b1; end
            COMP_Y:       res = y;
            COMP_NOT_Y:   res = ~y;
            COMP_NEG_Y:   res = 16'h0000 - y;
            COMP_Y_INC:   res = y + 16'h0001;
            COMP_Y_DEC:   res = y - 16'h0001;
            COMP_D_ADD_Y: res = d + y;
            COMP_D_SUB_Y: res = d - y;
            COMP_Y_SUB_D: res = y - d;
            COMP_D_AND_Y: res = d & y;
            COMP_D_OR_Y:  res = d | y;
            default:      known = 1'b0;
        endcase
    end

    assign neg  = res[15];
    assign zero = (res == 16'h0000);

    assign out.ok   = known && !(d_only && use_m);
    assign out.res  = res;
    assign out.take = (jbits[2] && neg) || (jbits[1] && zero) || (jbits[0] && !neg && !zero);

endmodule

`default_nettype wire

/* rtl/hcis_dmem.sv */
// data memory with registered read and clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module hcis_dmem import hcis_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 1024
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output word_t         rdata,
    output logic          clearing
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    word_t          mem [MEM_DEPTH];
    word_t          rdata_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  clr_cnt_next;
    logic           clearing_reg;
    logic           clearing_next;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(MEM_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

/* rtl/hack_cpu_instruction_step.sv */
// top level of the hack cpu instruction step block
`timescale 1ns / 1ps
`default_nettype none

// Executes one Hack instruction per item and returns one result item with the new
// counter, A, D, jump flag and status. An item is taken at the input edge, the M
// operand is read from the data memory at that same edge, and the result is
// registered in the output register when the execute stage fires; items may follow
// every cycle while the output is not stalled. A C-instruction with a=1 that arrives
// while the item ahead of it is an A-instruction or stores to A or M also waits
// until that item has executed, since the single memory read port needs the final A
// and the stored M when the item is taken. After reset the data memory is zeroed one
// word per cycle, so no item is taken until every word is cleared; configuration
// writes are taken throughout. MEM_DEPTH must be a power of two, the memory address being the low bits of A.

`include "hack_cpu_instruction_step_assert.svh"

module hack_cpu_instruction_step import hcis_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    hcis_instr_if.sink                 instr,
    hcis_result_if.source              result
);

    word_t    program_length;
    word_t    mem_rdata;
    logic     clearing;
    mem_req_t mem_req;
    alu_out_t alu_out;

    // architectural state
    word_t a_reg, a_next;
    word_t d_reg, d_next;
    word_t pc_reg, pc_next;
    logic  halted_reg, halted_next;

    // execute stage
    logic  e_valid_reg, e_valid_next;
    word_t e_instr_reg;

    // output register
    logic    out_valid_reg;
    word_t   out_pc_reg;
    word_t   out_a_reg;
    word_t   out_d_reg;
    logic    out_jumped_reg;
    status_t out_status_reg;

    logic    in_accept;
    logic    out_free;
    logic    e_fire;
    logic    hazard;
    logic    e_use_m;
    word_t   y_sel;
    logic    jumped;
    status_t status;
    logic    mem_we;

    hcis_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .program_length (program_length)
    );

    hcis_dmem #(.MEM_DEPTH(MEM_DEPTH)) u_dmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    assign e_use_m = e_instr_reg[12];
    assign y_sel   = e_use_m ? mem_rdata : a_reg;

    hcis_alu u_alu (
        .comp  (e_instr_reg[11:6]),
        .use_m (e_use_m),
        .jbits (e_instr_reg[2:0]),
        .d     (d_reg),
        .y     (y_sel),
        .out   (alu_out)
    );

    // an M read at accept needs A and M settled by the item ahead
    assign hazard = e_valid_reg && instr.instruction[15] && instr.instruction[12]
                    && (!e_instr_reg[15] || e_instr_reg[5] || e_instr_reg[3]);

    assign out_free    = !out_valid_reg || result.ready;
    assign e_fire      = e_valid_reg && out_free;
    assign instr.ready = !clearing && (!e_valid_reg || (out_free && !hazard));
    assign in_accept   = instr.valid && instr.ready;

    always_comb
    begin
        a_next      = a_reg;
        d_next      = d_reg;
        pc_next     = pc_reg;
        halted_next = halted_reg;
        jumped      = 1'b0;
        status      = ST_OK;
        mem_we      = 1'b0;
        if (halted_reg)
        begin
            status = ST_HALTED;
        end
        else if (pc_reg >= program_length)
        begin
            halted_next = 1'b1;
            status      = ST_RANGE;
        end
        else if (!e_instr_reg[15])
        begin
            a_next  = e_instr_reg & A_LOAD_MASK;
            pc_next = pc_reg + 16'h0001;
        end
        else if (!alu_out.ok)
        begin
            halted_next = 1'b1;
            status      = ST_BAD;
        end
        else
        begin
            mem_we = e_instr_reg[3];
            if (e_instr_reg[4])
            begin
                d_next = alu_out.res;
            end
            if (e_instr_reg[5])
            begin
                a_next = alu_out.res;
            end
            if (alu_out.take)
            begin
                pc_next = a_next;
                jumped  = 1'b1;
            end
            else
            begin
                pc_next = pc_reg + 16'h0001;
            end
        end
    end

    // store goes to the word at the old A
    assign mem_req.re    = in_accept;
    assign mem_req.raddr = a_reg;
    assign mem_req.we    = e_fire && mem_we;
    assign mem_req.waddr = a_reg;
    assign mem_req.wdata = alu_out.res;

    always_comb
    begin
        e_valid_next = e_valid_reg;
        if (in_accept)
        begin
            e_valid_next = 1'b1;
        end
        else if (e_fire)
        begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            d_reg         <= '0;
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            if (e_fire)
            begin
                a_reg         <= a_next;
                d_reg         <= d_next;
                pc_reg        <= pc_next;
                halted_reg    <= halted_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e_instr_reg <= instr.instruction;
        end
        if (e_fire)
        begin
            out_pc_reg     <= pc_next;
            out_a_reg      <= a_next;
            out_d_reg      <= d_next;
            out_jumped_reg <= jumped;
            out_status_reg <= status;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.next_pc = out_pc_reg;
    assign result.a_value = out_a_reg;
    assign result.d_value = out_d_reg;
    assign result.jumped  = out_jumped_reg;
    assign result.status  = out_status_reg;

    `HCIS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg)
    `HCIS_ASSERT_IMPL(a_fault_no_jump, clk, rst_n, result.valid && (result.status != ST_OK), !result.jumped)
    `HCIS_ASSERT_NEXT(a_stall_holds, clk, rst_n, e_valid_reg && !out_free, e_valid_reg && $stable(e_instr_reg))
    `HCIS_ASSERT_IMPL(a_no_item_in_clear, clk, rst_n, clearing, !instr.ready && !mem_req.we)

endmodule

`default_nettype wire
